// File: hdl/sgb_pkg.sv
`timescale 1ns / 1ps
package sgb_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 7;
    localparam int PIXEL_BITS = 16;
    localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int SLOT_W     = 4;
    localparam int ADDR_W     = 14;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RADIUS = 3'd2;
    localparam logic [2:0] REG_COEF_L = 3'd3;
    localparam logic [2:0] REG_COEF_H = 3'd4;

    // one run of outputs released by an input pixel
    typedef struct packed {
        logic [ROW_W-1:0] y0;
        logic [ROW_W-1:0] y1;
        logic [COL_W-1:0] x0;
        logic [COL_W-1:0] x1;
    } t_job;

    // effective frame settings
    typedef struct packed {
        logic [COL_W-1:0] wm1;
        logic [ROW_W-1:0] hm1;
        logic [2:0]       rad;
        logic [127:0]     coef;
    } t_cfg;

    // row modulo 15: 16 is 1 mod 15, so fold the hex digits and subtract once
    function automatic logic [SLOT_W-1:0] row_slot(input logic [ROW_W-1:0] y);
        logic [5:0] s1;
        logic [4:0] s2;
        s1 = {2'd0, y[3:0]} + {2'd0, y[7:4]} + {4'd0, y[9:8]};
        s2 = {1'b0, s1[3:0]} + {3'd0, s1[5:4]};
        return (s2 >= 5'd15) ? SLOT_W'(s2 - 5'd15) : s2[SLOT_W-1:0];
    endfunction

    function automatic logic [15:0] round_sat(input logic [36:0] acc);
        logic [36:0] v;
        v = (acc + 37'd16384) >> 15;
        return (v > 37'd65535) ? 16'hFFFF : v[15:0];
    endfunction
endpackage

// File: hdl/sgb_stream_if.sv
`timescale 1ns / 1ps
interface sgb_stream_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/separable_gaussian_blur.sv
`timescale 1ns / 1ps
// Separable Gaussian blur over a raster stream of 16-bit grey pixels with
// edge-clamped borders. The front accepts one pixel a cycle into the line
// store while a four-entry run queue has room; a pixel that opens a row waits
// until every queued run has been computed, since it overwrites the oldest
// stored row. The back computes each output with one store read per tap,
// limited by the single line-store read port. Runs wait in the queue, and
// input stalls when it fills. Write registers only while nothing is in
// flight. No clearing pass is done after reset.
module separable_gaussian_blur (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    sgb_stream_if.sink  s_in,
    sgb_stream_if.source m_out
);
    logic [10:0] r_w, r_h;
    logic [2:0]  r_rad;
    logic [63:0] r_cl, r_ch;
    sgb_pkg::t_cfg cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 11'd1024; r_h <= 11'd1024; r_rad <= '0;
            r_cl <= 64'd32768; r_ch <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgb_pkg::REG_WIDTH:  r_w <= i_cfg_data[10:0];
                sgb_pkg::REG_HEIGHT: r_h <= i_cfg_data[10:0];
                sgb_pkg::REG_RADIUS: r_rad <= i_cfg_data[2:0];
                sgb_pkg::REG_COEF_L: r_cl <= i_cfg_data;
                sgb_pkg::REG_COEF_H: r_ch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.wm1 = (r_w == 11'd0) ? 10'd0 : (r_w > 11'd1024) ? 10'd1023 : 10'(r_w - 1'b1);
        cfg.hm1 = (r_h == 11'd0) ? 10'd0 : (r_h > 11'd1024) ? 10'd1023 : 10'(r_h - 1'b1);
        cfg.rad = r_rad;
        cfg.coef = {r_ch, r_cl};
    end

    logic wr_en, jv, full, empty, pop, bbusy, busy;
    logic [sgb_pkg::ADDR_W-1:0] wa;
    logic [15:0] wd;
    sgb_pkg::t_job jin, jout;

    // any run queued or in progress
    assign busy = !empty || bbusy;

    sgb_front u_front (.i_clk, .i_rst_n, .i_cfg(cfg), .i_valid(s_in.valid),
        .o_ready(s_in.ready), .i_pixel(s_in.data), .o_wr_en(wr_en), .o_wr_addr(wa),
        .o_wr_data(wd), .o_job_valid(jv), .o_job(jin), .i_job_full(full),
        .i_busy(busy));

    sgb_queue u_queue (.i_clk, .i_rst_n, .i_push(jv), .i_job(jin), .o_full(full),
        .o_empty(empty), .i_pop(pop), .o_job(jout));

    sgb_back u_back (.i_clk, .i_rst_n, .i_cfg(cfg), .i_wr_en(wr_en), .i_wr_addr(wa),
        .i_wr_data(wd), .i_q_empty(empty), .i_job(jout), .o_pop(pop), .o_busy(bbusy),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_pixel(m_out.data[15:0]),
        .o_col(m_out.data[25:16]), .o_row(m_out.data[35:26]),
        .o_run_last(m_out.data[36]), .o_frame_last(m_out.data[37]));

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !jv) else $error("run queue overflow");
    // frame end always closes a run
    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.data[37]) |-> m_out.data[36]) else $error("frame end mid run");
    // output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> $stable(m_out.data)) else $error("output changed");
endmodule

// File: hdl/sgb_front.sv
`timescale 1ns / 1ps
module sgb_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sgb_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [15:0]               i_pixel,
    output logic                      o_wr_en,
    output logic [sgb_pkg::ADDR_W-1:0] o_wr_addr,
    output logic [15:0]               o_wr_data,
    output logic                      o_job_valid,
    output sgb_pkg::t_job             o_job,
    input  logic                      i_job_full,
    input  logic                      i_busy
);
    logic [sgb_pkg::COL_W-1:0] r_col, n_col, c;
    logic [sgb_pkg::ROW_W-1:0] r_row, n_row, row;
    logic [sgb_pkg::ROW_W:0]   y0s;
    logic [sgb_pkg::COL_W:0]   x0s;
    logic                      acc;

    // hold a row-opening pixel until all runs are done: it overwrites the oldest row
    assign o_ready = !i_job_full && !((c == '0) && i_busy);
    assign acc     = i_valid && o_ready;
    assign c   = (r_col > i_cfg.wm1) ? i_cfg.wm1 : r_col;
    assign row = (r_row > i_cfg.hm1) ? i_cfg.hm1 : r_row;

    // store the pixel
    assign o_wr_en   = acc;
    assign o_wr_addr = {sgb_pkg::row_slot(row), c};
    assign o_wr_data = i_pixel;

    // classify: which window run this pixel completes
    always_comb begin
        y0s = (row == i_cfg.hm1) ? {1'b0, i_cfg.hm1} - {8'd0, i_cfg.rad}
                                 : {1'b0, row} - {8'd0, i_cfg.rad};
        if (row == i_cfg.hm1 && y0s[sgb_pkg::ROW_W]) y0s = '0;
        x0s = (c == i_cfg.wm1) ? {1'b0, i_cfg.wm1} - {8'd0, i_cfg.rad}
                               : {1'b0, c} - {8'd0, i_cfg.rad};
        if (c == i_cfg.wm1 && x0s[sgb_pkg::COL_W]) x0s = '0;
        o_job.y0 = y0s[sgb_pkg::ROW_W-1:0];
        o_job.y1 = (row == i_cfg.hm1) ? i_cfg.hm1 : y0s[sgb_pkg::ROW_W-1:0];
        o_job.x0 = x0s[sgb_pkg::COL_W-1:0];
        o_job.x1 = (c == i_cfg.wm1) ? i_cfg.wm1 : x0s[sgb_pkg::COL_W-1:0];
        o_job_valid = acc && !y0s[sgb_pkg::ROW_W] && !x0s[sgb_pkg::COL_W];
    end

    // advance position
    always_comb begin
        n_col = c + 1'b1;
        n_row = row;
        if (c == i_cfg.wm1) begin
            n_col = '0;
            n_row = (row == i_cfg.hm1) ? '0 : row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end
endmodule

// File: hdl/sgb_queue.sv
`timescale 1ns / 1ps
module sgb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sgb_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output sgb_pkg::t_job o_job
);
    sgb_pkg::t_job r_mem [sgb_pkg::QDEPTH];
    logic [sgb_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [sgb_pkg::QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == 3'(sgb_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // track fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, i_pop};
        end
    end
endmodule

// File: hdl/sgb_back.sv
`timescale 1ns / 1ps
module sgb_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sgb_pkg::t_cfg              i_cfg,
    input  logic                       i_wr_en,
    input  logic [sgb_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [15:0]                i_wr_data,
    input  logic                       i_q_empty,
    input  sgb_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [15:0]                o_pixel,
    output logic [9:0]                 o_col,
    output logic [9:0]                 o_row,
    output logic                       o_run_last,
    output logic                       o_frame_last
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_VRD = 5'b00010, S_VEND = 5'b00100,
        S_HEND = 5'b01000, S_OUT = 5'b10000
    } t_state;

    logic [15:0] r_store [sgb_pkg::STORE_ROWS * sgb_pkg::MAX_WIDTH];
    logic [15:0] r_rd;
    t_state      r_st;
    sgb_pkg::t_job r_job;
    logic [9:0]  r_x, r_y;
    logic [3:0]  r_hk, r_vk;      // tap index 0..2R
    logic        r_rdv;
    logic [36:0] r_vacc, r_hacc;
    logic [15:0] r_prod_c;
    logic [31:0] r_prod;
    logic        r_pv;
    logic [15:0] wv_d;
    logic [11:0] xs, ys;
    logic [9:0]  xx, yy;
    logic [15:0] wv, wh;
    logic [31:0] hprod;
    logic [15:0] vres;

    function automatic logic [15:0] tapw(input logic [127:0] cf, input logic [3:0] i,
                                         input logic [2:0] rad);
        logic [3:0] k;
        k = (i > {1'b0, rad}) ? i - {1'b0, rad} : {1'b0, rad} - i;
        return cf[{k[2:0], 4'd0} +: 16];
    endfunction

    // clamped sample position for current taps
    always_comb begin
        xs = {2'd0, r_x} + {8'd0, r_hk} - {9'd0, i_cfg.rad};
        ys = {2'd0, r_y} + {8'd0, r_vk} - {9'd0, i_cfg.rad};
        xx = xs[11] ? 10'd0 : ((xs[10:0] > {1'b0, i_cfg.wm1}) ? i_cfg.wm1 : xs[9:0]);
        yy = ys[11] ? 10'd0 : ((ys[10:0] > {1'b0, i_cfg.hm1}) ? i_cfg.hm1 : ys[9:0]);
        wv = tapw(i_cfg.coef, r_vk, i_cfg.rad);
        wh = tapw(i_cfg.coef, r_hk, i_cfg.rad);
        hprod = 32'(r_prod_c) * 32'(wh);
        vres = sgb_pkg::round_sat(r_vacc);
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_store[i_wr_addr] <= i_wr_data;
        r_rd <= r_store[{sgb_pkg::row_slot(yy), xx}];
    end

    assign o_pop   = (r_st == S_IDLE) && !i_q_empty;
    assign o_busy  = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT);

    // sequence: vertical taps per column tap, then horizontal accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_rdv <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_rdv <= (r_st == S_VRD);
            r_pv  <= r_rdv;
            if (r_rdv) r_prod <= 32'(r_rd) * 32'(wv_d);
            if (r_pv) r_vacc <= r_vacc + {5'd0, r_prod};
            else if (r_st == S_IDLE || r_st == S_HEND) r_vacc <= '0;
            case (r_st)
                S_IDLE: if (!i_q_empty) begin
                    r_job <= i_job;
                    r_x <= i_job.x0;
                    r_y <= i_job.y0;
                    r_hk <= '0;
                    r_vk <= '0;
                    r_hacc <= '0;
                    r_st <= S_VRD;
                end
                S_VRD: begin
                    if (r_vk == {i_cfg.rad, 1'b0}) r_st <= S_VEND;
                    else r_vk <= r_vk + 1'b1;
                end
                S_VEND: if (!r_rdv && !r_pv) begin
                    r_prod_c <= vres;
                    r_st <= S_HEND;
                end
                S_HEND: begin
                    r_hacc <= r_hacc + {5'd0, hprod};
                    r_vk <= '0;
                    if (r_hk == {i_cfg.rad, 1'b0}) r_st <= S_OUT;
                    else begin
                        r_hk <= r_hk + 1'b1;
                        r_st <= S_VRD;
                    end
                end
                S_OUT: if (i_ready) begin
                    r_hk <= '0;
                    r_hacc <= '0;
                    if (r_x == r_job.x1) begin
                        r_x <= r_job.x0;
                        if (r_y == r_job.y1) r_st <= S_IDLE;
                        else begin
                            r_y <= r_y + 1'b1;
                            r_st <= S_VRD;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                        r_st <= S_VRD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) wv_d <= wv;

    assign o_pixel      = sgb_pkg::round_sat(r_hacc);
    assign o_col        = r_x;
    assign o_row        = r_y;
    assign o_run_last   = (r_x == r_job.x1) && (r_y == r_job.y1);
    assign o_frame_last = (r_x == i_cfg.wm1) && (r_y == i_cfg.hm1);
endmodule

// File: tb/sv/separable_gaussian_blur_tb.sv
`timescale 1ns / 1ps
module separable_gaussian_blur_tb;

    // one output pixel as carried on the result channel, pixel in the low bits
    typedef struct packed {
        logic        frame_last;
        logic        run_last;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [15:0] pix;
    } t_blur_px;

    localparam int OUT_W = $bits(t_blur_px);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    sgb_stream_if #(.W(16))    pix_if ();
    sgb_stream_if #(.W(OUT_W)) blur_if ();

    separable_gaussian_blur i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (pix_if.sink),
        .m_out      (blur_if.source)
    );

    // shadow of the block: line store, position and registers
    logic [15:0] line_mem [sgb_pkg::STORE_ROWS][sgb_pkg::MAX_WIDTH];
    int unsigned col_pos, row_pos;
    logic [10:0] width_reg, height_reg;
    logic [2:0]  radius_reg;
    logic [63:0] coef_lo_reg, coef_hi_reg;

    t_blur_px    pending_px [$];
    int          mismatches;
    int          send_idle_pct, recv_stall_pct;
    int          hold_off;
    int          pixels_sent;

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint unsigned tap_weight(input int k);
        if (k < 4)
            return (coef_lo_reg >> (16 * k)) & 64'hFFFF;
        return (coef_hi_reg >> (16 * (k - 4))) & 64'hFFFF;
    endfunction

    function automatic logic [15:0] round_clip(input longint unsigned acc);
        longint unsigned v;
        v = (acc + 64'd16384) >> 15;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic int clip(input int v, input int hi);
        if (v < 0)
            return 0;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [15:0] vertical_sum(input int x, input int y, input int h,
                                                 input int r);
        longint unsigned acc;
        int yy;
        acc = 0;
        for (int k = -r; k <= r; k++) begin
            yy = clip(y + k, h - 1);
            acc += tap_weight(k < 0 ? -k : k) * line_mem[yy % sgb_pkg::STORE_ROWS][x];
        end
        return round_clip(acc);
    endfunction

    function automatic logic [15:0] blurred_pixel(input int x, input int y, input int w,
                                                  input int h, input int r);
        longint unsigned acc;
        acc = 0;
        for (int k = -r; k <= r; k++)
            acc += tap_weight(k < 0 ? -k : k) * vertical_sum(clip(x + k, w - 1), y, h, r);
        return round_clip(acc);
    endfunction

    // store one accepted pixel and queue the outputs it releases
    function automatic void predict_pixel(input logic [15:0] p);
        int w, h, r, c, rw, y0, y1, x0, x1;
        t_blur_px e;
        w = (width_reg < 1) ? 1 : (width_reg > sgb_pkg::MAX_WIDTH) ? sgb_pkg::MAX_WIDTH
                                                                 : width_reg;
        h = (height_reg < 1) ? 1 : (height_reg > sgb_pkg::MAX_HEIGHT) ? sgb_pkg::MAX_HEIGHT
                                                                    : height_reg;
        r = radius_reg;
        c = (col_pos > w - 1) ? w - 1 : col_pos;
        rw = (row_pos > h - 1) ? h - 1 : row_pos;
        line_mem[rw % sgb_pkg::STORE_ROWS][c] = p;
        if (rw == h - 1) begin
            y0 = (h - 1 - r < 0) ? 0 : h - 1 - r;
            y1 = h - 1;
        end else begin
            y0 = rw - r;
            y1 = y0;
        end
        if (c == w - 1) begin
            x0 = (w - 1 - r < 0) ? 0 : w - 1 - r;
            x1 = w - 1;
        end else begin
            x0 = c - r;
            x1 = x0;
        end
        if (y0 >= 0 && x0 >= 0) begin
            for (int y = y0; y <= y1; y++) begin
                for (int x = x0; x <= x1; x++) begin
                    e.pix = blurred_pixel(x, y, w, h, r);
                    e.col = x[9:0];
                    e.row = y[9:0];
                    e.run_last = (y == y1 && x == x1);
                    e.frame_last = (x == w - 1 && y == h - 1);
                    pending_px = {pending_px, e};
                end
            end
        end
        // advance position
        if (c == w - 1) begin
            col_pos = 0;
            row_pos = (rw == h - 1) ? 0 : rw + 1;
        end else begin
            col_pos = c + 1;
            row_pos = rw;
        end
    endfunction

    // one register write; the caller drops the write enable after its last write
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            sgb_pkg::REG_WIDTH:  width_reg = val[10:0];
            sgb_pkg::REG_HEIGHT: height_reg = val[10:0];
            sgb_pkg::REG_RADIUS: radius_reg = val[2:0];
            sgb_pkg::REG_COEF_L: coef_lo_reg = val;
            sgb_pkg::REG_COEF_H: coef_hi_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h,
                             input logic [2:0] r, input logic [63:0] clo,
                             input logic [63:0] chi);
        write_reg(sgb_pkg::REG_WIDTH, 64'(w));
        write_reg(sgb_pkg::REG_HEIGHT, 64'(h));
        write_reg(sgb_pkg::REG_RADIUS, 64'(r));
        write_reg(sgb_pkg::REG_COEF_L, clo);
        write_reg(sgb_pkg::REG_COEF_H, chi);
        i_cfg_we <= 1'b0;
    endtask

    // one pixel transaction, with random idle cycles ahead of it
    task automatic send_pixel(input logic [15:0] p);
        if ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= p;
        do
            @(posedge i_clk);
        while (!pix_if.ready);
        predict_pixel(p);
        pixels_sent++;
    endtask

    // drop valid, then wait out every pending output plus the block's tail
    task automatic drain_outputs();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_px.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic send_frame(input int w, input int h, input int mode);
        logic [15:0] p;
        for (int i = 0; i < w * h; i++) begin
            case (mode)
                0: p = 16'($urandom);
                1: p = 16'hFFFF;
                2: p = 16'h0000;
                default: p = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
            endcase
            send_pixel(p);
        end
    endtask

    function automatic logic [63:0] rand_coef(input bit normalized);
        logic [63:0] c;
        for (int i = 0; i < 4; i++)
            c[16*i +: 16] = normalized ? 16'($urandom_range(12000)) : 16'($urandom);
        return c;
    endfunction

    task automatic test_extremes();
        // single pixel, widest kernel, all borders clamped
        set_frame(11'd1, 11'd1, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        drain_outputs();
        // saturating weights against full-scale pixels
        set_frame(11'd3, 11'd2, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(3, 2, 1);
        drain_outputs();
        // zero weights and one radius-one frame with a center tap only
        set_frame(11'd4, 11'd3, 3'd1, 64'h0000_0000_0000_8000, 64'h0);
        send_frame(4, 3, 0);
        drain_outputs();
    endtask

    task automatic test_size_clamps();
        // zero height acts as one row, oversize width as the full line: part of a row
        set_frame(11'd2047, 11'd0, 3'd0, 64'h0000_0000_0000_8000, 64'h0);
        send_frame(40, 1, 0);
        drain_outputs();
        // zero width acts as one column; the column counter clamps onto it
        set_frame(11'd0, 11'd3, 3'd2, rand_coef(1), rand_coef(1));
        send_frame(1, 3, 0);
        drain_outputs();
    endtask

    task automatic test_mid_frame_resize();
        set_frame(11'd3, 11'd5, 3'd0, 64'h0000_0000_0000_7FFF, 64'h0);
        send_frame(3, 2, 0);
        drain_outputs();
        // shrink the frame under the row counter: it acts as the last row
        write_reg(sgb_pkg::REG_HEIGHT, 64'd2);
        i_cfg_we <= 1'b0;
        send_frame(3, 1, 0);
        drain_outputs();
    endtask

    task automatic test_backpressure();
        set_frame(11'd6, 11'd4, 3'd2, rand_coef(1), rand_coef(1));
        send_idle_pct = 0;
        hold_off = 600;
        send_frame(6, 4, 0);
        drain_outputs();
    endtask

    task automatic test_random_frames();
        int w, h, mode;
        logic [2:0] r;
        mode = 0;
        while (pixels_sent < 300) begin
            case (mode % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            w = $urandom_range(12, 1);
            h = $urandom_range(6, 1);
            r = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
            set_frame(11'(w), 11'(h), r, rand_coef($urandom_range(3) != 0),
                      rand_coef($urandom_range(3) != 0));
            send_frame(w, h, $urandom_range(3));
            drain_outputs();
            mode++;
        end
    endtask

    // result sink: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            blur_if.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            blur_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each output transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_blur_px got, want;
        if (i_rst_n && blur_if.valid && blur_if.ready) begin
            got = blur_if.data;
            if (pending_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output %h", got);
            end else begin
                want = pending_px.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: got r%0d c%0d %h %b%b, want r%0d c%0d %h %b%b",
                                 got.row, got.col, got.pix, got.run_last, got.frame_last,
                                 want.row, want.col, want.pix, want.run_last,
                                 want.frame_last);
                end
            end
        end
    end

    initial begin
        #250_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = sgb_pkg::REG_WIDTH;
        i_cfg_data    = '0;
        pix_if.valid  = 1'b0;
        pix_if.data   = '0;
        blur_if.ready = 1'b0;
        mismatches    = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off      = 0;
        pixels_sent   = 0;
        col_pos       = 0;
        row_pos       = 0;
        width_reg     = 11'd1024;
        height_reg    = 11'd1024;
        radius_reg    = 3'd0;
        coef_lo_reg   = 64'd32768;
        coef_hi_reg   = 64'd0;
        for (int s = 0; s < sgb_pkg::STORE_ROWS; s++)
            for (int x = 0; x < sgb_pkg::MAX_WIDTH; x++)
                line_mem[s][x] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_size_clamps();
        test_mid_frame_resize();
        test_backpressure();
        test_random_frames();

        if (mismatches == 0 && pending_px.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: files.f
hdl/sgb_pkg.sv
hdl/sgb_stream_if.sv
hdl/sgb_front.sv
hdl/sgb_queue.sv
hdl/sgb_back.sv
hdl/separable_gaussian_blur.sv
tb/sv/separable_gaussian_blur_tb.sv
